[hdl/tptq_pkg.sv]
// Package for the tick priority task queue: sizes, codes, the queue entry type,
// the control bundle for the cell row, and the ordering, hash and bit-search functions.
// No dependencies.
package tptq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam int TICK_W = 64;
   localparam int PRIO_W = 8;
   localparam int ID_W   = 32;
   localparam int KEY_W  = 32;
   localparam int TIE_W  = 64;
   localparam int FUNC_W = 3;
   localparam int KIND_W = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 64;

   // Hash shift amounts.
   localparam int HASH_SHL_A = 13;
   localparam int HASH_SHR_B = 7;
   localparam int HASH_SHL_C = 17;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_SUBMIT     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUBMIT_NOW = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_STEP       = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_ADVANCE    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RESET_TICK = 3'd4;

   // Result kinds and status.
   localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FUZZ_ORDER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FUZZ_SEED  = 1'd1;

   // Cell row operations.
   localparam int CELL_OP_W = 3;
   localparam logic [CELL_OP_W-1:0] CELL_HOLD  = 3'd0;
   localparam logic [CELL_OP_W-1:0] CELL_WRITE = 3'd1;
   localparam logic [CELL_OP_W-1:0] CELL_LOAD  = 3'd2;
   localparam logic [CELL_OP_W-1:0] CELL_SORT  = 3'd3;
   localparam logic [CELL_OP_W-1:0] CELL_SHIFT = 3'd4;

   typedef struct packed {
      logic              valid;
      logic              due;
      logic [TICK_W-1:0] tick;
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   id;
      logic [KEY_W-1:0]  key;
      logic [TIE_W-1:0]  tie;
      logic [SLOT_W-1:0] slot;
   } entry_type;

   typedef struct packed {
      logic [CELL_OP_W-1:0]  op;
      logic                  parity;
      logic [TICK_W-1:0]     step_tick;
      logic                  fuzz_order;
      logic [TIE_W-1:0]      fuzz_seed;
      logic [SLOT_W-1:0]     wr_pos;
      entry_type             wr_entry;
   } chain_ctrl_type;

   // Seeded xorshift of an arrival number.
   function automatic logic [TIE_W-1:0] mix_key(input logic [KEY_W-1:0] n,
                                                input logic [TIE_W-1:0] seed);
      logic [TIE_W-1:0] x;
      x = TIE_W'(n) ^ seed;
      x = x ^ (x << HASH_SHL_A);
      x = x ^ (x >> HASH_SHR_B);
      x = x ^ (x << HASH_SHL_C);
      return x;
   endfunction

   // True when entry a leaves before entry b: tick, then priority, then tie key,
   // then slot number.
   function automatic logic goes_before(input entry_type a, input entry_type b);
      return {a.tick, a.prio, a.tie, a.slot} < {b.tick, b.prio, b.tie, b.slot};
   endfunction

   // Position of the lowest clear bit; zero when none is clear.
   function automatic logic [SLOT_W-1:0] lowest_clear(input logic [QUEUE_DEPTH-1:0] vec);
      logic [SLOT_W-1:0] pos;
      pos = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!vec[i]) begin
            pos = SLOT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

[hdl/tptq_cell.sv]
// One cell of the queue row: holds one entry and trades it with its neighbors.
// Depends on tptq_pkg.
module tptq_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  tptq_pkg::chain_ctrl_type ctrl,
   input  logic                    pos_odd,
   input  logic                    wr_sel,
   input  tptq_pkg::entry_type     left_entry,
   input  logic                    left_flag,
   input  tptq_pkg::entry_type     right_entry,
   output tptq_pkg::entry_type     entry,
   output logic                    right_first
);

   tptq_pkg::entry_type entry_ff;
   tptq_pkg::entry_type entry_in;

   // The right neighbor should sit ahead of this cell: due entries come first,
   // in queue order among themselves.
   assign right_first = right_entry.due &&
                        (!entry_ff.due || tptq_pkg::goes_before(right_entry, entry_ff));

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         tptq_pkg::CELL_WRITE: begin
            if (wr_sel) begin
               entry_in = ctrl.wr_entry;
            end
         end
         tptq_pkg::CELL_LOAD: begin
            entry_in.due = entry_ff.valid && (entry_ff.tick <= ctrl.step_tick);
            entry_in.tie = ctrl.fuzz_order ?
                           tptq_pkg::mix_key(entry_ff.key, ctrl.fuzz_seed) :
                           tptq_pkg::TIE_W'(entry_ff.key);
         end
         tptq_pkg::CELL_SORT: begin
            if (pos_odd == ctrl.parity) begin
               if (right_first) begin
                  entry_in = right_entry;
               end
            end else if (left_flag) begin
               entry_in = left_entry;
            end
         end
         tptq_pkg::CELL_SHIFT: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         entry_ff.due   <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

[hdl/tptq_chain.sv]
// The row of queue cells with its neighbor wiring; cell zero is the head.
// Depends on tptq_pkg and tptq_cell.
module tptq_chain (
   input  logic                                clock,
   input  logic                                reset,
   input  tptq_pkg::chain_ctrl_type            ctrl,
   output tptq_pkg::entry_type                 head,
   output logic [tptq_pkg::QUEUE_DEPTH-1:0]    cell_valid
);

   localparam tptq_pkg::entry_type EMPTY_ENTRY = '0;

   tptq_pkg::entry_type entries [tptq_pkg::QUEUE_DEPTH];
   logic                flags   [tptq_pkg::QUEUE_DEPTH];

   for (genvar i = 0; i < tptq_pkg::QUEUE_DEPTH; i++) begin : g_cell
      tptq_pkg::entry_type left_e;
      tptq_pkg::entry_type right_e;
      logic                left_f;

      if (i == 0) begin : g_first
         assign left_e = EMPTY_ENTRY;
         assign left_f = 1'b0;
      end else begin : g_mid_left
         assign left_e = entries[i-1];
         assign left_f = flags[i-1];
      end

      if (i == tptq_pkg::QUEUE_DEPTH - 1) begin : g_last
         assign right_e = EMPTY_ENTRY;
      end else begin : g_mid_right
         assign right_e = entries[i+1];
      end

      tptq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .pos_odd     ((i % 2) == 1),
         .wr_sel      (ctrl.wr_pos == tptq_pkg::SLOT_W'(i)),
         .left_entry  (left_e),
         .left_flag   (left_f),
         .right_entry (right_e),
         .entry       (entries[i]),
         .right_first (flags[i])
      );

      assign cell_valid[i] = entries[i].valid;
   end

   assign head = entries[0];

endmodule

[hdl/tick_priority_task_queue.sv]
// Top level of the tick priority task queue: handshakes, configuration,
// tick and id counters, slot allocation and the step sequencer.
// Depends on tptq_pkg and tptq_chain (which uses tptq_cell).
//
//   Channel   Direction  Handshake          Contents
//   req_      in         req_valid/stall    func, due_tick, prio, tick_delta
//   rsp_      out        rsp_valid/stall    kind, status, task_id, task_tick,
//                                           task_prio, now_tick, last
//   csr_      in         csr_we             csr_index, csr_wdata (no read-back)
//
// A submit, advance, tick reset or unused code is captured, then executed into
// the output register as soon as that register is free. A step is captured,
// executed, then goes through a load step in which every cell marks itself due
// and forms its tie key, QUEUE_DEPTH rounds of odd-even transposition sort along
// the cell row, and an emit phase that gives one result per due task and then
// the step-finished result, as the row shifts toward the head.
// Reset is synchronous; no clearing pass is needed.
// A stalled result holds the output register and the sequencer waits for it; a
// new item is taken as soon as the sequencer is back in idle.
module tick_priority_task_queue (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tptq_pkg::FUNC_W-1:0]      req_func,
   input  logic [tptq_pkg::TICK_W-1:0]      req_due_tick,
   input  logic [tptq_pkg::PRIO_W-1:0]      req_prio,
   input  logic [tptq_pkg::TICK_W-1:0]      req_tick_delta,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tptq_pkg::KIND_W-1:0]      rsp_kind,
   output logic                             rsp_status,
   output logic [tptq_pkg::ID_W-1:0]        rsp_task_id,
   output logic [tptq_pkg::TICK_W-1:0]      rsp_task_tick,
   output logic [tptq_pkg::PRIO_W-1:0]      rsp_task_prio,
   output logic [tptq_pkg::TICK_W-1:0]      rsp_now_tick,
   output logic                             rsp_last,

   input  logic                             csr_we,
   input  logic [tptq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tptq_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_SORT = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;

   // Captured request.
   logic [tptq_pkg::FUNC_W-1:0] cmd_func_ff,  cmd_func_in;
   logic [tptq_pkg::TICK_W-1:0] cmd_due_ff,   cmd_due_in;
   logic [tptq_pkg::PRIO_W-1:0] cmd_prio_ff,  cmd_prio_in;
   logic [tptq_pkg::TICK_W-1:0] cmd_delta_ff, cmd_delta_in;

   // Architectural state outside the cell row.
   logic [tptq_pkg::TICK_W-1:0]      now_ff, now_in;
   logic [tptq_pkg::TICK_W-1:0]      step_tick_ff, step_tick_in;
   logic [tptq_pkg::ID_W-1:0]        id_ff, id_in;
   logic [tptq_pkg::KEY_W-1:0]       arr_ff, arr_in;
   logic [tptq_pkg::QUEUE_DEPTH-1:0] slot_used_ff, slot_used_in;
   logic [tptq_pkg::SLOT_W-1:0]      round_ff, round_in;
   logic                             fuzz_order_ff;
   logic [tptq_pkg::TIE_W-1:0]       fuzz_seed_ff;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tptq_pkg::KIND_W-1:0]  rsp_kind_ff,  rsp_kind_in;
   logic                         rsp_status_ff, rsp_status_in;
   logic [tptq_pkg::ID_W-1:0]    rsp_id_ff,    rsp_id_in;
   logic [tptq_pkg::TICK_W-1:0]  rsp_tick_ff,  rsp_tick_in;
   logic [tptq_pkg::PRIO_W-1:0]  rsp_prio_ff,  rsp_prio_in;
   logic [tptq_pkg::TICK_W-1:0]  rsp_now_ff,   rsp_now_in;
   logic                         rsp_last_ff,  rsp_last_in;

   tptq_pkg::chain_ctrl_type          ctrl;
   tptq_pkg::entry_type               head;
   logic [tptq_pkg::QUEUE_DEPTH-1:0]  cell_valid;

   logic req_accept;
   logic out_free;
   logic out_load;
   logic queue_full;
   logic [tptq_pkg::SLOT_W-1:0] free_slot;
   logic [tptq_pkg::SLOT_W-1:0] free_cell;
   logic [tptq_pkg::TICK_W-1:0] submit_tick;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign queue_full = &slot_used_ff;

   // The slot number decides ties only; the entry itself goes into the lowest empty cell.
   assign free_slot   = tptq_pkg::lowest_clear(slot_used_ff);
   assign free_cell   = tptq_pkg::lowest_clear(cell_valid);
   assign submit_tick = (cmd_func_ff == tptq_pkg::FUNC_SUBMIT_NOW) ? now_ff : cmd_due_ff;

   tptq_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .head       (head),
      .cell_valid (cell_valid)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_func_in  = cmd_func_ff;
      cmd_due_in   = cmd_due_ff;
      cmd_prio_in  = cmd_prio_ff;
      cmd_delta_in = cmd_delta_ff;
      now_in       = now_ff;
      step_tick_in = step_tick_ff;
      id_in        = id_ff;
      arr_in       = arr_ff;
      slot_used_in = slot_used_ff;
      round_in     = round_ff;

      out_load      = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_tick_in   = rsp_tick_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_now_in    = rsp_now_ff;
      rsp_last_in   = rsp_last_ff;

      ctrl                = '0;
      ctrl.op             = tptq_pkg::CELL_HOLD;
      ctrl.parity         = round_ff[0];
      ctrl.step_tick      = step_tick_ff;
      ctrl.fuzz_order     = fuzz_order_ff;
      ctrl.fuzz_seed      = fuzz_seed_ff;
      ctrl.wr_pos         = free_cell;
      ctrl.wr_entry.valid = 1'b1;
      ctrl.wr_entry.due   = 1'b0;
      ctrl.wr_entry.tick  = submit_tick;
      ctrl.wr_entry.prio  = cmd_prio_ff;
      ctrl.wr_entry.id    = id_ff;
      ctrl.wr_entry.key   = arr_ff;
      ctrl.wr_entry.slot  = free_slot;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_func_in  = req_func;
               cmd_due_in   = req_due_tick;
               cmd_prio_in  = req_prio;
               cmd_delta_in = req_tick_delta;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd_func_ff == tptq_pkg::FUNC_STEP) begin
               // The step works on the tick before the increment; every result
               // of the step reports the incremented tick.
               step_tick_in = now_ff;
               now_in       = now_ff + 1'b1;
               state_in     = ST_LOAD;
            end else if (out_free) begin
               out_load      = 1'b1;
               rsp_kind_in   = tptq_pkg::KIND_ACK;
               rsp_status_in = tptq_pkg::STATUS_OK;
               rsp_id_in     = '0;
               rsp_tick_in   = '0;
               rsp_prio_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
               unique case (cmd_func_ff) inside
                  tptq_pkg::FUNC_SUBMIT, tptq_pkg::FUNC_SUBMIT_NOW: begin
                     if (queue_full) begin
                        rsp_status_in = tptq_pkg::STATUS_FULL;
                     end else begin
                        ctrl.op                 = tptq_pkg::CELL_WRITE;
                        slot_used_in[free_slot] = 1'b1;
                        id_in                   = id_ff + 1'b1;
                        arr_in                  = arr_ff + 1'b1;
                        rsp_id_in               = id_ff;
                        rsp_tick_in             = submit_tick;
                        rsp_prio_in             = cmd_prio_ff;
                     end
                  end
                  tptq_pkg::FUNC_ADVANCE: begin
                     now_in = now_ff + cmd_delta_ff;
                  end
                  tptq_pkg::FUNC_RESET_TICK: begin
                     now_in = '0;
                  end
                  default: begin
                     now_in = now_ff;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            ctrl.op  = tptq_pkg::CELL_LOAD;
            round_in = '0;
            state_in = ST_SORT;
         end
         ST_SORT: begin
            ctrl.op  = tptq_pkg::CELL_SORT;
            round_in = round_ff + 1'b1;
            if (round_ff == tptq_pkg::SLOT_W'(tptq_pkg::QUEUE_DEPTH - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = tptq_pkg::STATUS_OK;
               if (head.due) begin
                  // Due tasks sit at the head in leave order; pop one per cycle while the output register is free.
                  ctrl.op                 = tptq_pkg::CELL_SHIFT;
                  slot_used_in[head.slot] = 1'b0;
                  rsp_kind_in             = tptq_pkg::KIND_RUN;
                  rsp_id_in               = head.id;
                  rsp_tick_in             = head.tick;
                  rsp_prio_in             = head.prio;
                  rsp_last_in             = 1'b0;
               end else begin
                  rsp_kind_in = tptq_pkg::KIND_DONE;
                  rsp_id_in   = '0;
                  rsp_tick_in = '0;
                  rsp_prio_in = '0;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_now_in = now_in;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         id_ff         <= '0;
         arr_ff        <= '0;
         slot_used_ff  <= '0;
         round_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         fuzz_order_ff <= 1'b0;
         fuzz_seed_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         id_ff        <= id_in;
         arr_ff       <= arr_in;
         slot_used_ff <= slot_used_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               tptq_pkg::CSR_FUZZ_ORDER: fuzz_order_ff <= csr_wdata[0];
               tptq_pkg::CSR_FUZZ_SEED:  fuzz_seed_ff  <= csr_wdata;
               default: begin
                  fuzz_order_ff <= fuzz_order_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_func_ff   <= cmd_func_in;
      cmd_due_ff    <= cmd_due_in;
      cmd_prio_ff   <= cmd_prio_in;
      cmd_delta_ff  <= cmd_delta_in;
      step_tick_ff  <= step_tick_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_tick_ff   <= rsp_tick_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_now_ff    <= rsp_now_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_task_id   = rsp_id_ff;
   assign rsp_task_tick = rsp_tick_ff;
   assign rsp_task_prio = rsp_prio_ff;
   assign rsp_now_tick  = rsp_now_ff;
   assign rsp_last      = rsp_last_ff;

   // The slot map and the cell row always hold the same number of tasks.
   a_slot_count: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_used_ff) == $countones(cell_valid))
      else $error("slot map and cell row disagree on occupancy");

   // A due entry at the head during emission owns a slot in use.
   a_head_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && head.due) |-> slot_used_ff[head.slot])
      else $error("due head entry has no slot in use");

   // A refused submit leaves the id counter alone.
   a_full_keeps_id: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && out_free && queue_full &&
       (cmd_func_ff == tptq_pkg::FUNC_SUBMIT || cmd_func_ff == tptq_pkg::FUNC_SUBMIT_NOW))
      |=> (id_ff == $past(id_ff)))
      else $error("id counter moved on a refused submit");

endmodule
